@@ src/skip_gram_phrase_generator_unit_macros.svh @@
// Assertion macros for the skip-gram phrase generator checker.
// Needs no other file; included by the checker only.
`ifndef SKIP_GRAM_PHRASE_GENERATOR_UNIT_MACROS_SVH
`define SKIP_GRAM_PHRASE_GENERATOR_UNIT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define SGPG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SGPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `SGPG_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

@@ src/sgpg_pkg.sv @@
// Package of the skip-gram phrase generator: sizes and the phrase pattern table.
// Depends on nothing; used by every module of the block.
`default_nettype none

package sgpg_pkg;

  localparam int unsigned HistDepth   = 6;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned PageBits    = 24;
  localparam int unsigned NumPatterns = 13;
  localparam int unsigned PatIdxBits  = 4;
  localparam int unsigned BackBits    = 3;

  localparam logic [1:0] LenUni = 2'd1;
  localparam logic [1:0] LenBi  = 2'd2;
  localparam logic [1:0] LenTri = 2'd3;

  // Patterns in output order: unigram, bigrams with gap 0..2, then trigrams
  // by first-to-middle distance and, within that, middle-to-last distance.
  function automatic logic [1:0] pat_len(input logic [PatIdxBits-1:0] idx);
    logic [1:0] len;
    unique case (idx)
      4'd0:                len = LenUni;
      4'd1, 4'd2, 4'd3:    len = LenBi;
      default:             len = LenTri;
    endcase
    return len;
  endfunction

  // Distance back from the current word to the first word of the phrase.
  // It is also the history depth the pattern needs.
  function automatic logic [BackBits-1:0] pat_back_a(input logic [PatIdxBits-1:0] idx);
    logic [BackBits-1:0] back;
    unique case (idx)
      4'd0:           back = 3'd0;
      4'd1:           back = 3'd1;
      4'd2, 4'd4:     back = 3'd2;
      4'd3, 4'd5:     back = 3'd3;
      4'd7:           back = 3'd3;
      4'd6, 4'd8:     back = 3'd4;
      4'd10:          back = 3'd4;
      4'd9, 4'd11:    back = 3'd5;
      4'd12:          back = 3'd6;
      default:        back = 3'd0;
    endcase
    return back;
  endfunction

  // Distance back to the middle word of a trigram.
  function automatic logic [BackBits-1:0] pat_back_b(input logic [PatIdxBits-1:0] idx);
    logic [BackBits-1:0] back;
    unique case (idx)
      4'd4, 4'd7, 4'd10:  back = 3'd1;
      4'd5, 4'd8, 4'd11:  back = 3'd2;
      4'd6, 4'd9, 4'd12:  back = 3'd3;
      default:            back = 3'd1;
    endcase
    return back;
  endfunction

endpackage

`default_nettype wire

@@ src/sgpg_if.sv @@
// Valid/ready channel interfaces of the skip-gram phrase generator.
// Depends on sgpg_pkg for the field widths.
`default_nettype none

interface sgpg_in_if;
  logic                              valid;
  logic                              ready;
  logic [sgpg_pkg::WordBits-1:0]     word_hash;
  logic [sgpg_pkg::PageBits-1:0]     page_id;
  logic                              first_of_page;

  modport source (output valid, output word_hash, output page_id, output first_of_page,
                  input ready);
  modport sink   (input valid, input word_hash, input page_id, input first_of_page,
                  output ready);
endinterface

interface sgpg_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        phrase_length;
  logic [sgpg_pkg::PageBits-1:0]     page_id_out;
  logic [sgpg_pkg::WordBits-1:0]     word_a;
  logic [sgpg_pkg::WordBits-1:0]     word_b;
  logic [sgpg_pkg::WordBits-1:0]     word_c;
  logic                              last_of_run;

  modport source (output valid, output phrase_length, output page_id_out, output word_a,
                  output word_b, output word_c, output last_of_run, input ready);
  modport sink   (input valid, input phrase_length, input page_id_out, input word_a,
                  input word_b, input word_c, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ src/skip_gram_phrase_generator_unit.sv @@
// Top level of the skip-gram phrase generator.
// Depends on sgpg_pkg, sgpg_if, sgpg_window and sgpg_emitter.
//
// Usage. Each request on in_i carries one word hash, its page id and a
// first-of-page flag. For every word the block sends the phrases that end
// at it on out_o: the unigram, bigrams with gaps of zero to two words and
// up to nine trigrams, skipping any phrase that reaches before the page
// start. last_of_run marks the final phrase of a word.
// The first phrase of a word is formed from the request register and then held
// in the result register. Throughput: one phrase per cycle while the receiver
// does not stall; a word gives 1 to 13 phrases, all leaving through the single
// result register. The next request is taken in the cycle the last
// phrase of the current word moves into that register, even while it still waits.
// Reset empties the history and drops any request or phrase in flight.
// When the receiver stalls, the held phrase stays unchanged, the walk over
// the patterns pauses and in_i.ready falls once the request register holds
// a word whose phrases are still pending.
// Only the low HASH_BITS bits of a hash are kept (all of them above 32).
`default_nettype none

module skip_gram_phrase_generator_unit #(
  parameter int unsigned HASH_BITS = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sgpg_in_if.sink      in_i,
  sgpg_out_if.source   out_o
);

  localparam int unsigned KeepBits =
    (HASH_BITS < sgpg_pkg::WordBits) ? HASH_BITS : sgpg_pkg::WordBits;

  logic [KeepBits-1:0]           cur;
  logic [KeepBits-1:0]           snap [sgpg_pkg::HistDepth];
  logic [sgpg_pkg::BackBits-1:0] avail;
  logic                          accept;

  assign cur    = in_i.word_hash[KeepBits-1:0];
  assign accept = in_i.valid && in_i.ready;

  // History is updated as the request is taken; the emitter keeps the snapshot.
  sgpg_window #(
    .KeepBits (KeepBits)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cur_i    (cur),
    .first_i  (in_i.first_of_page),
    .snap_o   (snap),
    .avail_o  (avail)
  );

  sgpg_emitter #(
    .KeepBits (KeepBits)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .cur_i       (cur),
    .page_i      (in_i.page_id),
    .snap_i      (snap),
    .avail_i     (avail),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .len_o       (out_o.phrase_length),
    .page_o      (out_o.page_id_out),
    .word_a_o    (out_o.word_a),
    .word_b_o    (out_o.word_b),
    .word_c_o    (out_o.word_c),
    .last_o      (out_o.last_of_run)
  );

endmodule

`default_nettype wire

@@ src/sgpg_window.sv @@
// Word history of the current page: six earlier hashes and a fill count.
// Depends on sgpg_pkg.
`default_nettype none

module sgpg_window #(
  parameter int unsigned KeepBits = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               accept_i,
  input  wire logic [KeepBits-1:0]                cur_i,
  input  wire logic                               first_i,
  output logic      [KeepBits-1:0]                snap_o [sgpg_pkg::HistDepth],
  output logic      [sgpg_pkg::BackBits-1:0]      avail_o
);

  logic [KeepBits-1:0]           hist_q [sgpg_pkg::HistDepth];
  logic [KeepBits-1:0]           hist_d [sgpg_pkg::HistDepth];
  logic [sgpg_pkg::BackBits-1:0] count_q, count_d;

  // A new page hides all earlier words from the incoming one.
  always_comb begin
    for (int k = 0; k < sgpg_pkg::HistDepth; k++) begin
      snap_o[k] = first_i ? '0 : hist_q[k];
    end
    avail_o = first_i ? '0 : count_q;
  end

  always_comb begin
    hist_d[0] = cur_i;
    for (int k = 1; k < sgpg_pkg::HistDepth; k++) begin
      hist_d[k] = snap_o[k-1];
    end
    if (avail_o == sgpg_pkg::BackBits'(sgpg_pkg::HistDepth)) begin
      count_d = avail_o;
    end else begin
      count_d = avail_o + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < sgpg_pkg::HistDepth; k++) begin
        hist_q[k] <= '0;
      end
    end else if (accept_i) begin
      count_q <= count_d;
      hist_q  <= hist_d;
    end
  end

endmodule

`default_nettype wire

@@ src/sgpg_emitter.sv @@
// Request register and result register: walks the valid phrase patterns of one
// word, one result per cycle unless the receiver stalls. Depends on sgpg_pkg.
`default_nettype none

module sgpg_emitter #(
  parameter int unsigned KeepBits = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [KeepBits-1:0]                cur_i,
  input  wire logic [sgpg_pkg::PageBits-1:0]      page_i,
  input  wire logic [KeepBits-1:0]                snap_i [sgpg_pkg::HistDepth],
  input  wire logic [sgpg_pkg::BackBits-1:0]      avail_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [1:0]                         len_o,
  output logic      [sgpg_pkg::PageBits-1:0]      page_o,
  output logic      [sgpg_pkg::WordBits-1:0]      word_a_o,
  output logic      [sgpg_pkg::WordBits-1:0]      word_b_o,
  output logic      [sgpg_pkg::WordBits-1:0]      word_c_o,
  output logic                                    last_o
);

  // Request held while its phrases are emitted.
  logic                               job_valid_q;
  logic [KeepBits-1:0]                cur_q;
  logic [sgpg_pkg::PageBits-1:0]      page_q;
  logic [KeepBits-1:0]                win_q [sgpg_pkg::HistDepth];
  logic [sgpg_pkg::NumPatterns-1:0]   mask_q, mask_d, load_mask, pick_hot;

  logic [sgpg_pkg::PatIdxBits-1:0]    pick;
  logic [sgpg_pkg::BackBits-1:0]      back_a, back_b;
  logic [KeepBits-1:0]                sel_a, sel_b, sel_c;
  logic [1:0]                         sel_len;
  logic                               sel_last, emit, accept;

  // Which patterns fit within the page history of the incoming word.
  always_comb begin
    for (int k = 0; k < sgpg_pkg::NumPatterns; k++) begin
      load_mask[k] = sgpg_pkg::pat_back_a(sgpg_pkg::PatIdxBits'(k)) <= avail_i;
    end
  end

  // Lowest pending pattern goes next.
  always_comb begin
    pick = '0;
    for (int k = sgpg_pkg::NumPatterns - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        pick = sgpg_pkg::PatIdxBits'(k);
      end
    end
    pick_hot = sgpg_pkg::NumPatterns'(1) << pick;
    mask_d   = mask_q & ~pick_hot;
    sel_last = (mask_d == '0);
  end

  always_comb begin
    sel_len = sgpg_pkg::pat_len(pick);
    back_a  = sgpg_pkg::pat_back_a(pick);
    back_b  = sgpg_pkg::pat_back_b(pick);
    sel_a   = (back_a == '0) ? cur_q : win_q[back_a - 3'd1];
    sel_b   = '0;
    sel_c   = '0;
    unique case (sel_len)
      sgpg_pkg::LenBi: begin
        sel_b = cur_q;
      end
      sgpg_pkg::LenTri: begin
        sel_b = win_q[back_b - 3'd1];
        sel_c = cur_q;
      end
      default: begin
        sel_b = '0;
      end
    endcase
  end

  assign emit       = job_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !job_valid_q || (emit && sel_last);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      mask_q      <= '0;
    end else if (accept) begin
      job_valid_q <= 1'b1;
      mask_q      <= load_mask;
    end else if (emit) begin
      job_valid_q <= !sel_last;
      mask_q      <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q  <= cur_i;
      page_q <= page_i;
      win_q  <= snap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      len_o    <= sel_len;
      page_o   <= page_q;
      word_a_o <= sgpg_pkg::WordBits'(sel_a);
      word_b_o <= sgpg_pkg::WordBits'(sel_b);
      word_c_o <= sgpg_pkg::WordBits'(sel_c);
      last_o   <= sel_last;
    end
  end

endmodule

`default_nettype wire

@@ src/sgpg_checker.sv @@
// Port-level checks of the skip-gram phrase generator, bound to its top level.
// Depends on sgpg_pkg and the assertion macro header.
`default_nettype none
`include "skip_gram_phrase_generator_unit_macros.svh"

module sgpg_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [1:0]                     phrase_length_i,
  input wire logic [sgpg_pkg::WordBits-1:0]  word_a_i,
  input wire logic [sgpg_pkg::WordBits-1:0]  word_b_i,
  input wire logic [sgpg_pkg::WordBits-1:0]  word_c_i,
  input wire logic                           last_of_run_i
);

  // A stalled phrase keeps its valid, first word, length and last flag.
  `SGPG_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(word_a_i) && $stable(phrase_length_i) && $stable(last_of_run_i), "stalled phrase changed")

  // No phrase is ever empty.
  `SGPG_ASSERT(a_len, clk_i, rst_ni, out_valid_i |-> phrase_length_i != 2'd0, "phrase length zero")

  // Unused word slots of a unigram are zero.
  `SGPG_ASSERT(a_uni, clk_i, rst_ni, out_valid_i && phrase_length_i == sgpg_pkg::LenUni |-> word_b_i == '0 && word_c_i == '0, "unigram carries extra words")

  // A bigram has no third word.
  `SGPG_ASSERT(a_bi, clk_i, rst_ni, out_valid_i && phrase_length_i == sgpg_pkg::LenBi |-> word_c_i == '0, "bigram carries a third word")

endmodule

bind skip_gram_phrase_generator_unit sgpg_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .phrase_length_i (out_o.phrase_length),
  .word_a_i        (out_o.word_a),
  .word_b_i        (out_o.word_b),
  .word_c_i        (out_o.word_c),
  .last_of_run_i   (out_o.last_of_run)
);

`default_nettype wire

@@ bench/skip_gram_phrase_generator_unit_test.sv @@
// Self-checking bench for the skip-gram phrase generator, one word per request.
// Depends on sgpg_pkg, sgpg_if and the RTL of skip_gram_phrase_generator_unit.
// A behavioural predictor of the phrase window supplies every expected phrase but those of typed rows.
`default_nettype none

module skip_gram_phrase_generator_unit_test;

  // Idle-cycle budget for the watchdog. The long receiver hold-off is the longest
  // legitimate stretch without any handshake, so this leaves a wide margin.
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned LongHold      = 150;
  localparam int unsigned RandomWords   = 184;
  localparam int unsigned NumDirected   = 16;
  localparam int unsigned MaxReported   = 10;
  // Up to thirteen phrases per word.
  localparam int unsigned DrainCycles   = 32;

  typedef struct packed {
    logic [1:0]                    len;
    logic [sgpg_pkg::PageBits-1:0] page;
    logic [sgpg_pkg::WordBits-1:0] a;
    logic [sgpg_pkg::WordBits-1:0] b;
    logic [sgpg_pkg::WordBits-1:0] c;
    logic                          last;
  } phrase_t;

  // One row of the directed table. Where typed is set, the word can only
  // produce its unigram, so that phrase is written out here by hand.
  typedef struct packed {
    logic [sgpg_pkg::WordBits-1:0] word;
    logic [sgpg_pkg::PageBits-1:0] page;
    logic                          first;
    bit                            typed;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sgpg_in_if  in_ch ();
  sgpg_out_if out_ch ();

  skip_gram_phrase_generator_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: the recent words of the current page, newest first.
  logic [sgpg_pkg::WordBits-1:0] recent_words [sgpg_pkg::HistDepth];
  int unsigned                   recent_count;
  phrase_t                       predicted_run [$];
  phrase_t                       pending_phrases [$];

  int unsigned words_sent;
  int unsigned pages_started;
  int unsigned full_windows;
  int unsigned phrases_checked;
  int unsigned mismatch_count;

  // Idling is switched per page, independently for each side, so that some
  // stretches run flat out and others have gaps on every phase.
  bit sender_gaps_on;
  bit receiver_gaps_on;
  bit hold_request;
  bit hold_done;

  // The directed table walks the history from empty to full and then past it,
  // changes the page id without the flag, and hits the extremes of every field.
  stim_row_t directed_rows [NumDirected] = '{
    '{32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, 1'b1},  // straight after reset: empty history
    '{32'h0000_0001, 24'h00_0001, 1'b1, 1'b1},  // page start
    '{32'h0000_0002, 24'h00_0001, 1'b0, 1'b0},
    '{32'h0000_0004, 24'h00_0001, 1'b0, 1'b0},
    '{32'h0000_0008, 24'h00_0001, 1'b0, 1'b0},
    '{32'h0000_0010, 24'h00_0001, 1'b0, 1'b0},
    '{32'h0000_0020, 24'h00_0001, 1'b0, 1'b0},
    '{32'h0000_0040, 24'h00_0001, 1'b0, 1'b0},  // six words back: all thirteen phrases
    '{32'h8000_0000, 24'h00_0001, 1'b0, 1'b0},  // history full, oldest word drops out
    '{32'h5555_5555, 24'h00_0002, 1'b0, 1'b0},  // new page id but no flag
    '{32'hAAAA_AAAA, 24'h80_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 24'h00_0000, 1'b1, 1'b1},  // all-zero word at a page start
    '{32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, 1'b0},
    '{32'h1234_5678, 24'h00_0000, 1'b1, 1'b1},
    '{32'h8765_4321, 24'h12_3456, 1'b1, 1'b1},  // two page starts back to back
    '{32'h0F0F_0F0F, 24'h12_3456, 1'b0, 1'b0}
  };

  // Works out every phrase that ends at this word, in the order the block
  // sends them, and then moves the word into the history.
  function automatic void predict_phrases(input logic [sgpg_pkg::WordBits-1:0] word,
                                          input logic [sgpg_pkg::PageBits-1:0] page,
                                          input logic                          first);
    logic [sgpg_pkg::WordBits-1:0] back_word [sgpg_pkg::HistDepth+1];
    int unsigned                   avail;
    predicted_run.delete();
    if (first) begin
      recent_count = 0;
      foreach (recent_words[k]) recent_words[k] = '0;
    end
    avail = recent_count;
    back_word[0] = word;
    for (int k = 1; k <= sgpg_pkg::HistDepth; k++) back_word[k] = recent_words[k-1];

    predicted_run.insert(predicted_run.size(), '{sgpg_pkg::LenUni, page, word, '0, '0, 1'b0});
    for (int gap = 0; gap < 3; gap++) begin
      if (gap + 1 <= avail) begin
        predicted_run.insert(predicted_run.size(),
                             '{sgpg_pkg::LenBi, page, back_word[gap+1], word, '0, 1'b0});
      end
    end
    // Trigrams: first-to-middle distance outside, middle-to-last inside.
    for (int d1 = 1; d1 <= 3; d1++) begin
      for (int d2 = 1; d2 <= 3; d2++) begin
        if (d1 + d2 <= avail) begin
          predicted_run.insert(predicted_run.size(),
                               '{sgpg_pkg::LenTri, page, back_word[d1+d2], back_word[d2],
                                 word, 1'b0});
        end
      end
    end
    predicted_run[predicted_run.size()-1].last = 1'b1;

    for (int k = sgpg_pkg::HistDepth - 1; k > 0; k--) recent_words[k] = recent_words[k-1];
    recent_words[0] = word;
    recent_count = (avail < sgpg_pkg::HistDepth) ? avail + 1 : sgpg_pkg::HistDepth;
  endfunction

  function automatic void note_mismatch(input string what, input phrase_t want,
                                        input phrase_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("MISMATCH %s at phrase %0d: expected len=%0d page=%06h a=%08h b=%08h c=%08h last=%0b",
               what, phrases_checked, want.len, want.page, want.a, want.b, want.c, want.last);
      $display("         got                  len=%0d page=%06h a=%08h b=%08h c=%08h last=%0b",
               got.len, got.page, got.a, got.b, got.c, got.last);
    end
  endfunction

  // Offers one word as a request and, once it has been taken, queues the phrases
  // it must cause. Valid is only lowered when a gap is actually drawn, so a
  // back-to-back request never sees valid dropped and raised in one step.
  task automatic offer_word(input logic [sgpg_pkg::WordBits-1:0] word,
                            input logic [sgpg_pkg::PageBits-1:0] page,
                            input logic first, input bit typed);
    int unsigned gap;
    gap = sender_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.word_hash     <= word;
    in_ch.page_id       <= page;
    in_ch.first_of_page <= first;
    do @(posedge clk_i); while (!in_ch.ready);

    predict_phrases(word, page, first);
    if (typed) begin
      pending_phrases.insert(pending_phrases.size(),
                             '{sgpg_pkg::LenUni, page, word, '0, '0, 1'b1});
    end else begin
      foreach (predicted_run[k]) pending_phrases.insert(pending_phrases.size(), predicted_run[k]);
    end
    if (predicted_run.size() == sgpg_pkg::NumPatterns) full_windows++;
    if (first) pages_started++;
    words_sent++;
  endtask

  // Main sequence: reset, directed table, then random pages, then the drain.
  initial begin
    logic [sgpg_pkg::PageBits-1:0] page;
    int unsigned                   page_len;
    int unsigned                   quiet_pages;
    bit                            flagged_start;

    in_ch.valid         = 1'b0;
    in_ch.word_hash     = '0;
    in_ch.page_id       = '0;
    in_ch.first_of_page = 1'b0;
    sender_gaps_on      = 1'b0;
    receiver_gaps_on    = 1'b0;
    hold_request        = 1'b0;
    recent_count        = 0;
    foreach (recent_words[k]) recent_words[k] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed rows go through with idling on both sides.
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
    foreach (directed_rows[r]) begin
      offer_word(directed_rows[r].word, directed_rows[r].page,
                 directed_rows[r].first, directed_rows[r].typed);
    end

    // Random part. The first few pages run without sender gaps while the
    // receiver holds off, so the block fills up and has to stall its input.
    hold_request = 1'b1;
    quiet_pages  = 3;
    while (words_sent < NumDirected + RandomWords) begin
      page = sgpg_pkg::PageBits'($urandom);
      // Most pages are short; now and then one is long enough to fill the window.
      page_len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 8);
      // One page in ten changes the id without raising the flag.
      flagged_start = ($urandom_range(0, 9) != 0);
      if (quiet_pages != 0) begin
        quiet_pages--;
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b0;
      end else begin
        sender_gaps_on   = ($urandom_range(0, 2) != 0);
        receiver_gaps_on = ($urandom_range(0, 2) != 0);
      end
      for (int i = 0; i < page_len; i++) begin
        // A stray page start in the middle of a page is the noise here.
        offer_word(sgpg_pkg::WordBits'($urandom), page,
                   (i == 0) ? flagged_start : ($urandom_range(0, 19) == 0), 1'b0);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_phrases.size() != 0) @(posedge clk_i);
    // Any phrase that turns up now has no expectation and is flagged by the receiver.
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_phrases.size() != 0) begin
      $display("%0d expected phrases never arrived", pending_phrases.size());
      mismatch_count += pending_phrases.size();
    end

    $display("Offered %0d words over %0d flagged page starts; %0d of them had a full window.",
             words_sent, pages_started, full_windows);
    $display("Checked %0d phrases, with a receiver hold-off of %0d cycles along the way.",
             phrases_checked, LongHold);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: draws a stall before each phrase, takes it, and checks it
  // against the oldest expectation. The long hold-off happens once, when
  // the main sequence asks for it.
  initial begin
    phrase_t     got;
    phrase_t     want;
    int unsigned stall;
    bit          bad;

    out_ch.ready    = 1'b0;
    hold_done       = 1'b0;
    phrases_checked = 0;
    mismatch_count  = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request && !hold_done) begin
        stall     = LongHold;
        hold_done = 1'b1;
      end else begin
        stall = receiver_gaps_on ? $urandom_range(0, 14) : 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);

      got = '{out_ch.phrase_length, out_ch.page_id_out, out_ch.word_a,
              out_ch.word_b, out_ch.word_c, out_ch.last_of_run};
      if (pending_phrases.size() == 0) begin
        note_mismatch("unexpected phrase", '0, got);
      end else begin
        want = pending_phrases.pop_front();
        bad  = (got.len !== want.len) || (got.page !== want.page) ||
               (got.a !== want.a) || (got.b !== want.b) ||
               (got.c !== want.c) || (got.last !== want.last);
        if (bad) note_mismatch("wrong field", want, got);
      end
      phrases_checked++;
    end
  end

  // Watchdog: counts edges at which neither channel completes a handshake.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Timeout: no handshake for %0d cycles, %0d phrases still expected",
                 quiet_cycles, pending_phrases.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

@@ skip_gram_phrase_generator_unit.f @@
+incdir+src
src/sgpg_pkg.sv
src/sgpg_if.sv
src/sgpg_window.sv
src/sgpg_emitter.sv
src/skip_gram_phrase_generator_unit.sv
src/sgpg_checker.sv
bench/skip_gram_phrase_generator_unit_test.sv
